FILE: rtl/qea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qea_pkg;

    localparam int QW = 16;          // quaternion component width, Q1.15
    localparam int PRW = 32;         // exact product width, Q2.30
    localparam int SW = 34;          // sums of products, Q.30 with headroom
    localparam int CW = 36;          // CORDIC x and y width
    localparam int ZW = 27;          // CORDIC angle accumulator, degrees Q.16
    localparam int AW = 15;          // output angle width, degrees Q9.6
    localparam int RW = 31;          // square root width
    localparam int VW = 2 * RW;      // radicand width
    localparam int TABLE_LEN = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [1:0] ORD_ZYX = 2'd0;
    localparam logic [1:0] ORD_XZY = 2'd1;
    localparam logic [1:0] ORD_YZX = 2'd2;
    localparam logic [1:0] ORD_XYZ = 2'd3;

    localparam logic signed [SW-1:0] LOCK_LIMIT = 34'sd1073741287;
    localparam logic signed [SW-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [ZW-1:0] DEG180_Q16 = 27'sd11796480;
    localparam logic signed [AW-1:0] ANGLE_SAT = 15'sd11520;
    localparam logic signed [AW-1:0] DEG90_Q96 = 15'sd5760;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    // Arctangent of 2^-i in degrees, Q.16, rounded.
    function automatic logic signed [ZW-1:0] atan_deg_q16(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0: a = 27'sd2949120;
            1: a = 27'sd1740967;
            2: a = 27'sd919879;
            3: a = 27'sd466945;
            4: a = 27'sd234379;
            5: a = 27'sd117304;
            6: a = 27'sd58666;
            7: a = 27'sd29335;
            8: a = 27'sd14668;
            9: a = 27'sd7334;
            10: a = 27'sd3667;
            11: a = 27'sd1833;
            12: a = 27'sd917;
            13: a = 27'sd458;
            14: a = 27'sd229;
            15: a = 27'sd115;
            16: a = 27'sd57;
            17: a = 27'sd29;
            18: a = 27'sd14;
            19: a = 27'sd7;
            20: a = 27'sd4;
            21: a = 27'sd2;
            22: a = 27'sd1;
            default: a = 27'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qea_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module qea_cordic #(
    parameter int STEPS = qea_pkg::CORDIC_STEPS_DEF
) (
    input  wire                              aclk,
    input  wire                              en,
    input  wire logic signed [qea_pkg::CW-1:0] x_in,
    input  wire logic signed [qea_pkg::CW-1:0] y_in,
    output logic signed [qea_pkg::AW-1:0]    angle
);

    qea_pkg::cordic_t stage_reg [0:STEPS];
    qea_pkg::cordic_t stage_next [0:STEPS];

    // Vectors in the left half plane are turned by 180 degrees first.
    always_comb begin
        stage_next[0].zero = (x_in == '0) && (y_in == '0);
        if (x_in < 0) begin
            stage_next[0].x = -x_in;
            stage_next[0].y = -y_in;
            stage_next[0].z = (y_in >= 0) ? qea_pkg::DEG180_Q16 : -qea_pkg::DEG180_Q16;
        end else begin
            stage_next[0].x = x_in;
            stage_next[0].y = y_in;
            stage_next[0].z = '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_step
            always_comb begin
                stage_next[i+1].zero = stage_reg[i].zero;
                if (stage_reg[i].y >= 0) begin
                    stage_next[i+1].x = stage_reg[i].x + (stage_reg[i].y >>> i);
                    stage_next[i+1].y = stage_reg[i].y - (stage_reg[i].x >>> i);
                    stage_next[i+1].z = stage_reg[i].z + qea_pkg::atan_deg_q16(i);
                end else begin
                    stage_next[i+1].x = stage_reg[i].x - (stage_reg[i].y >>> i);
                    stage_next[i+1].y = stage_reg[i].y + (stage_reg[i].x >>> i);
                    stage_next[i+1].z = stage_reg[i].z - qea_pkg::atan_deg_q16(i);
                end
            end
        end
        for (i = 0; i <= STEPS; i++) begin : g_reg
            always_ff @(posedge aclk) begin
                if (en) begin
                    stage_reg[i] <= stage_next[i];
                end
            end
        end
    endgenerate

    // Degrees Q.16 to Q9.6 with rounding and saturation.
    logic signed [qea_pkg::ZW:0]   z_round;
    logic signed [qea_pkg::ZW-10:0] z_q96;

    always_comb begin
        z_round = stage_reg[STEPS].zero ? '0
                : ((qea_pkg::ZW+1)'(stage_reg[STEPS].z) + (qea_pkg::ZW+1)'(512));
        z_q96 = (qea_pkg::ZW-9)'(z_round >>> 10);
        if (z_q96 > (qea_pkg::ZW-9)'(qea_pkg::ANGLE_SAT)) begin
            angle = qea_pkg::ANGLE_SAT;
        end else if (z_q96 < -(qea_pkg::ZW-9)'(qea_pkg::ANGLE_SAT)) begin
            angle = -qea_pkg::ANGLE_SAT;
        end else begin
            angle = qea_pkg::AW'(z_q96);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    s_quat_w/x/y/z, s_rotation_order
// m_       out        m_valid / m_ready    m_angle_x/y/z, m_gimbal_lock
//
// One item enters per cycle while m_ready does not stall the output; the pipeline holds four stages
// of permute, multiply, sum and square, 31 root stages (one result bit each),
// then the CORDIC prep stage, CORDIC_STEPS rotation stages and the output register.
// Reset clears only the valid bits. A stall at m_ready freezes the whole pipeline
// in place, so s_ready is low exactly while the output item is held.

module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = qea_pkg::CORDIC_STEPS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire logic signed [qea_pkg::QW-1:0] s_quat_w,
    input  wire logic signed [qea_pkg::QW-1:0] s_quat_x,
    input  wire logic signed [qea_pkg::QW-1:0] s_quat_y,
    input  wire logic signed [qea_pkg::QW-1:0] s_quat_z,
    input  wire logic [1:0]                    s_rotation_order,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic signed [qea_pkg::AW-1:0]      m_angle_x,
    output logic signed [qea_pkg::AW-1:0]      m_angle_y,
    output logic signed [qea_pkg::AW-1:0]      m_angle_z,
    output logic                               m_gimbal_lock
);

    localparam int QW = qea_pkg::QW;
    localparam int PRW = qea_pkg::PRW;
    localparam int SW = qea_pkg::SW;
    localparam int CW = qea_pkg::CW;
    localparam int AW = qea_pkg::AW;
    localparam int RW = qea_pkg::RW;
    localparam int VW = qea_pkg::VW;

    typedef struct packed {
        logic                 valid;
        logic                 lock;
        logic                 s_neg;
        logic [1:0]           ord;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [SW-1:0] s;
        logic [VW-1:0]        v;
        logic [RW+3:0]        rem;
        logic [RW-1:0]        root;
    } sqrt_t;

    typedef struct packed {
        logic       valid;
        logic       lock;
        logic       s_neg;
        logic [1:0] ord;
    } side_t;

    logic adv;
    logic m_valid_reg;
    logic signed [AW-1:0] m_angle_x_reg, m_angle_y_reg, m_angle_z_reg;
    logic m_gimbal_lock_reg;

    assign adv = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage 1: permute the components for the rotation order.
    logic signed [QW-1:0] p1_next, p2_next, p3_next;
    logic neg_next;
    logic v1_reg, neg1_reg;
    logic [1:0] ord1_reg;
    logic signed [QW-1:0] p0_1_reg, p1_1_reg, p2_1_reg, p3_1_reg;

    always_comb begin
        case (s_rotation_order)
            qea_pkg::ORD_ZYX: begin
                p1_next = s_quat_z; p2_next = s_quat_y; p3_next = s_quat_x; neg_next = 1'b1;
            end
            qea_pkg::ORD_XZY: begin
                p1_next = s_quat_x; p2_next = s_quat_z; p3_next = s_quat_y; neg_next = 1'b1;
            end
            qea_pkg::ORD_YZX: begin
                p1_next = s_quat_y; p2_next = s_quat_z; p3_next = s_quat_x; neg_next = 1'b0;
            end
            default: begin
                p1_next = s_quat_x; p2_next = s_quat_y; p3_next = s_quat_z; neg_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
        if (adv) begin
            p0_1_reg <= s_quat_w;
            p1_1_reg <= p1_next;
            p2_1_reg <= p2_next;
            p3_1_reg <= p3_next;
            neg1_reg <= neg_next;
            ord1_reg <= s_rotation_order;
        end
    end

    // Stage 2: the products, exact in Q2.30.
    logic v2_reg, neg2_reg;
    logic [1:0] ord2_reg;
    logic signed [QW-1:0] p0_2_reg, p1_2_reg;
    logic signed [PRW-1:0] m01_reg, m02_reg, m03_reg, m12_reg, m13_reg, m23_reg;
    logic signed [PRW-1:0] m11_reg, m22_reg, m33_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            m01_reg <= p0_1_reg * p1_1_reg;
            m02_reg <= p0_1_reg * p2_1_reg;
            m03_reg <= p0_1_reg * p3_1_reg;
            m12_reg <= p1_1_reg * p2_1_reg;
            m13_reg <= p1_1_reg * p3_1_reg;
            m23_reg <= p2_1_reg * p3_1_reg;
            m11_reg <= p1_1_reg * p1_1_reg;
            m22_reg <= p2_1_reg * p2_1_reg;
            m33_reg <= p3_1_reg * p3_1_reg;
            p0_2_reg <= p0_1_reg;
            p1_2_reg <= p1_1_reg;
            neg2_reg <= neg1_reg;
            ord2_reg <= ord1_reg;
        end
    end

    // Stage 3: sine term, the outer atan2 operands and the lock test.
    logic signed [SW-1:0] s_next, n1_next, d1_next, n3_next, d3_next;
    logic lock_next;
    logic signed [CW-1:0] ax_next, ay_next;
    logic v3_reg, lock3_reg;
    logic [1:0] ord3_reg;
    logic signed [SW-1:0] s3_reg;
    logic signed [CW-1:0] ax3_reg, ay3_reg, cx3_reg, cy3_reg;

    always_comb begin
        if (neg2_reg) begin
            s_next = (SW'(m02_reg) - SW'(m13_reg)) <<< 1;
            n1_next = (SW'(m01_reg) + SW'(m23_reg)) <<< 1;
            n3_next = (SW'(m03_reg) + SW'(m12_reg)) <<< 1;
        end else begin
            s_next = (SW'(m02_reg) + SW'(m13_reg)) <<< 1;
            n1_next = (SW'(m01_reg) - SW'(m23_reg)) <<< 1;
            n3_next = (SW'(m03_reg) - SW'(m12_reg)) <<< 1;
        end
        d1_next = qea_pkg::ONE_Q30 - ((SW'(m11_reg) + SW'(m22_reg)) <<< 1);
        d3_next = qea_pkg::ONE_Q30 - ((SW'(m22_reg) + SW'(m33_reg)) <<< 1);
        lock_next = (s_next > qea_pkg::LOCK_LIMIT) || (s_next < -qea_pkg::LOCK_LIMIT);
        // In gimbal lock the first angle is atan2(p1, p0) instead.
        if (lock_next) begin
            ax_next = CW'(p0_2_reg) <<< 15;
            ay_next = CW'(p1_2_reg) <<< 15;
        end else begin
            ax_next = CW'(d1_next);
            ay_next = CW'(n1_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            s3_reg <= s_next;
            lock3_reg <= lock_next;
            ord3_reg <= ord2_reg;
            ax3_reg <= ax_next;
            ay3_reg <= ay_next;
            cx3_reg <= CW'(d3_next);
            cy3_reg <= CW'(n3_next);
        end
    end

    // Stage 4: radicand 1 - S^2 in Q.60. Only used without lock, where |S| < 2^30.
    logic [SW-1:0] s_mag;
    logic [RW-1:0] s_mag_cut;
    logic [VW-1:0] s_sq;
    sqrt_t sq_reg [0:RW];
    sqrt_t sq_next [0:RW];

    always_comb begin
        s_mag = (s3_reg < 0) ? SW'(-s3_reg) : SW'(s3_reg);
        s_mag_cut = s_mag[RW-1:0];
        s_sq = VW'(s_mag_cut) * VW'(s_mag_cut);
        sq_next[0].valid = v3_reg;
        sq_next[0].lock = lock3_reg;
        sq_next[0].s_neg = s3_reg[SW-1];
        sq_next[0].ord = ord3_reg;
        sq_next[0].ax = ax3_reg;
        sq_next[0].ay = ay3_reg;
        sq_next[0].cx = cx3_reg;
        sq_next[0].cy = cy3_reg;
        sq_next[0].s = s3_reg;
        sq_next[0].v = {2'b01, {(VW-2){1'b0}}} - s_sq;
        sq_next[0].rem = '0;
        sq_next[0].root = '0;
    end

    // Square root, one result bit per stage.
    logic [RW+3:0] rem_sh [0:RW-1];
    logic [RW+3:0] trial [0:RW-1];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_sqrt
            always_comb begin
                sq_next[k+1] = sq_reg[k];
                rem_sh[k] = {sq_reg[k].rem[RW+1:0], sq_reg[k].v[VW-1 -: 2]};
                trial[k] = {2'b00, sq_reg[k].root, 2'b01};
                sq_next[k+1].v = sq_reg[k].v << 2;
                if (rem_sh[k] >= trial[k]) begin
                    sq_next[k+1].rem = rem_sh[k] - trial[k];
                    sq_next[k+1].root = {sq_reg[k].root[RW-2:0], 1'b1};
                end else begin
                    sq_next[k+1].rem = rem_sh[k];
                    sq_next[k+1].root = {sq_reg[k].root[RW-2:0], 1'b0};
                end
            end
        end
        for (k = 0; k <= RW; k++) begin : g_sqrt_reg
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq_reg[k].valid <= 1'b0;
                end else if (adv) begin
                    sq_reg[k] <= sq_next[k];
                end
            end
        end
    endgenerate

    // Three CORDIC units in step, with the control bits traveling beside them.
    logic signed [AW-1:0] ang_a, ang_b, ang_c;

    qea_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (sq_reg[RW].ax),
        .y_in  (sq_reg[RW].ay),
        .angle (ang_a)
    );

    qea_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (CW'(sq_reg[RW].root)),
        .y_in  (CW'(sq_reg[RW].s)),
        .angle (ang_b)
    );

    qea_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_c (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (sq_reg[RW].cx),
        .y_in  (sq_reg[RW].cy),
        .angle (ang_c)
    );

    side_t side_reg [0:CORDIC_STEPS];
    side_t side_next [0:CORDIC_STEPS];

    always_comb begin
        side_next[0].valid = sq_reg[RW].valid;
        side_next[0].lock = sq_reg[RW].lock;
        side_next[0].s_neg = sq_reg[RW].s_neg;
        side_next[0].ord = sq_reg[RW].ord;
    end

    genvar j;
    generate
        for (j = 1; j <= CORDIC_STEPS; j++) begin : g_side
            assign side_next[j] = side_reg[j-1];
        end
        for (j = 0; j <= CORDIC_STEPS; j++) begin : g_side_reg
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    side_reg[j].valid <= 1'b0;
                end else if (adv) begin
                    side_reg[j] <= side_next[j];
                end
            end
        end
    endgenerate

    // Output stage: lock solution and permutation back onto the axes.
    side_t side_out;
    logic signed [AW-1:0] a1, a2, a3;
    logic signed [AW-1:0] angle_x_next, angle_y_next, angle_z_next;

    assign side_out = side_reg[CORDIC_STEPS];

    always_comb begin
        a1 = ang_a;
        if (side_out.lock) begin
            a2 = side_out.s_neg ? -qea_pkg::DEG90_Q96 : qea_pkg::DEG90_Q96;
            a3 = '0;
        end else begin
            a2 = ang_b;
            a3 = ang_c;
        end
        case (side_out.ord)
            qea_pkg::ORD_ZYX: begin
                angle_x_next = a3; angle_y_next = a2; angle_z_next = a1;
            end
            qea_pkg::ORD_XZY: begin
                angle_x_next = a1; angle_y_next = a3; angle_z_next = a2;
            end
            qea_pkg::ORD_YZX: begin
                angle_x_next = a3; angle_y_next = a1; angle_z_next = a2;
            end
            default: begin
                angle_x_next = a1; angle_y_next = a2; angle_z_next = a3;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= side_out.valid;
        end
        if (adv) begin
            m_angle_x_reg <= angle_x_next;
            m_angle_y_reg <= angle_y_next;
            m_angle_z_reg <= angle_z_next;
            m_gimbal_lock_reg <= side_out.lock;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_angle_x = m_angle_x_reg;
    assign m_angle_y = m_angle_y_reg;
    assign m_angle_z = m_angle_z_reg;
    assign m_gimbal_lock = m_gimbal_lock_reg;

    // A locked item carries a zero third angle on some axis.
    a_lock_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_gimbal_lock |-> (m_angle_x == '0 || m_angle_y == '0 || m_angle_z == '0))
        else $error("gimbal lock item without a zero angle");

    // A locked item carries plus or minus 90 degrees on some axis.
    a_lock_ninety: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_gimbal_lock |->
            (m_angle_x == qea_pkg::DEG90_Q96 || m_angle_x == -qea_pkg::DEG90_Q96 ||
             m_angle_y == qea_pkg::DEG90_Q96 || m_angle_y == -qea_pkg::DEG90_Q96 ||
             m_angle_z == qea_pkg::DEG90_Q96 || m_angle_z == -qea_pkg::DEG90_Q96))
        else $error("gimbal lock item without a 90 degree angle");

    // Saturation keeps every angle within plus or minus 180 degrees.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_x <= qea_pkg::ANGLE_SAT && m_angle_x >= -qea_pkg::ANGLE_SAT &&
                     m_angle_y <= qea_pkg::ANGLE_SAT && m_angle_y >= -qea_pkg::ANGLE_SAT &&
                     m_angle_z <= qea_pkg::ANGLE_SAT && m_angle_z >= -qea_pkg::ANGLE_SAT))
        else $error("angle out of range");

endmodule

`default_nettype wire

FILE: dv/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;

    localparam int NSTEPS = qea_pkg::CORDIC_STEPS_DEF;
    localparam int N_RANDOM = 1650;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [qea_pkg::QW-1:0] w;
        logic signed [qea_pkg::QW-1:0] x;
        logic signed [qea_pkg::QW-1:0] y;
        logic signed [qea_pkg::QW-1:0] z;
        logic [1:0]                    order;
    } quat_item_t;

    typedef struct packed {
        logic signed [qea_pkg::AW-1:0] ax;
        logic signed [qea_pkg::AW-1:0] ay;
        logic signed [qea_pkg::AW-1:0] az;
        logic                          lock;
    } euler_item_t;

    // Arctangent of 2^-i in degrees, Q.16, rounded.
    localparam longint ATAN_DEG[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [qea_pkg::QW-1:0] s_quat_w = '0;
    logic signed [qea_pkg::QW-1:0] s_quat_x = '0;
    logic signed [qea_pkg::QW-1:0] s_quat_y = '0;
    logic signed [qea_pkg::QW-1:0] s_quat_z = '0;
    logic [1:0] s_rotation_order = qea_pkg::ORD_ZYX;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [qea_pkg::AW-1:0] m_angle_x;
    logic signed [qea_pkg::AW-1:0] m_angle_y;
    logic signed [qea_pkg::AW-1:0] m_angle_z;
    logic m_gimbal_lock;

    quat_item_t  quat_pending[$];
    euler_item_t angles_due[$];
    int n_sent = 0;
    int n_errors = 0;
    int hold_at = 900;
    bit hold_done = 1'b0;
    int sender_idle_pct = 8;
    int receiver_idle_pct = 78;
    longint n_cycles = 0;

    quaternion_to_euler_angles #(.CORDIC_STEPS(NSTEPS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x), .s_quat_y(s_quat_y),
        .s_quat_z(s_quat_z), .s_rotation_order(s_rotation_order),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_angle_x(m_angle_x), .m_angle_y(m_angle_y), .m_angle_z(m_angle_z),
        .m_gimbal_lock(m_gimbal_lock)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Vectoring CORDIC, result in degrees Q.16.
    function automatic longint atan2_deg(longint y, longint x);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            ang = (y >= 0) ? 11796480 : -11796480;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < NSTEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                ang = ang + ATAN_DEG[i];
            end else begin
                x = x - dx;
                y = y + dy;
                ang = ang - ATAN_DEG[i];
            end
        end
        return ang;
    endfunction

    function automatic logic signed [qea_pkg::AW-1:0] deg_q96(longint ang);
        longint r;
        r = (ang + 512) >>> 10;
        if (r > 11520) r = 11520;
        if (r < -11520) r = -11520;
        return r[qea_pkg::AW-1:0];
    endfunction

    function automatic euler_item_t euler_of(quat_item_t q);
        longint p0, p1, p2, p3, s, n1, d1, n3, d3;
        logic signed [qea_pkg::AW-1:0] t1, t2, t3;
        bit neg;
        euler_item_t e;
        p0 = q.w;
        case (q.order)
            qea_pkg::ORD_ZYX: begin p1 = q.z; p2 = q.y; p3 = q.x; neg = 1; end
            qea_pkg::ORD_XZY: begin p1 = q.x; p2 = q.z; p3 = q.y; neg = 1; end
            qea_pkg::ORD_YZX: begin p1 = q.y; p2 = q.z; p3 = q.x; neg = 0; end
            default: begin p1 = q.x; p2 = q.y; p3 = q.z; neg = 0; end
        endcase
        s = 2 * (neg ? (p0 * p2 - p1 * p3) : (p0 * p2 + p1 * p3));
        e.lock = (s > 1073741287) || (s < -1073741287);
        if (e.lock) begin
            t1 = deg_q96(atan2_deg(p1 * 32768, p0 * 32768));
            t2 = (s >= 0) ? qea_pkg::DEG90_Q96 : -qea_pkg::DEG90_Q96;
            t3 = '0;
        end else begin
            n1 = 2 * (neg ? (p0 * p1 + p2 * p3) : (p0 * p1 - p2 * p3));
            d1 = 1073741824 - 2 * (p1 * p1 + p2 * p2);
            n3 = 2 * (neg ? (p0 * p3 + p1 * p2) : (p0 * p3 - p1 * p2));
            d3 = 1073741824 - 2 * (p2 * p2 + p3 * p3);
            t1 = deg_q96(atan2_deg(n1, d1));
            t2 = deg_q96(atan2_deg(s, floor_sqrt((64'd1 << 60) - s * s)));
            t3 = deg_q96(atan2_deg(n3, d3));
        end
        case (q.order)
            qea_pkg::ORD_ZYX: begin e.ax = t3; e.ay = t2; e.az = t1; end
            qea_pkg::ORD_XZY: begin e.ax = t1; e.ay = t3; e.az = t2; end
            qea_pkg::ORD_YZX: begin e.ax = t3; e.ay = t1; e.az = t2; end
            default: begin e.ax = t1; e.ay = t2; e.az = t3; end
        endcase
        return e;
    endfunction

    function automatic quat_item_t make_quat(int a, int b, int c, int d, int ord);
        quat_item_t q;
        q.w = a[qea_pkg::QW-1:0];
        q.x = b[qea_pkg::QW-1:0];
        q.y = c[qea_pkg::QW-1:0];
        q.z = d[qea_pkg::QW-1:0];
        q.order = ord[1:0];
        return q;
    endfunction

    task automatic queue_quat(quat_item_t q);
        quat_pending = {quat_pending, q};
    endtask

    function automatic int rnd_comp();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Random direction scaled to unit length, optionally pushed toward gimbal lock.
    function automatic quat_item_t unit_quat(bit near_lock);
        real v[4];
        real n;
        int ord;
        ord = $urandom_range(3);
        for (int i = 0; i < 4; i++) v[i] = real'(rnd_comp());
        if (near_lock) begin
            for (int i = 0; i < 4; i++) v[i] = v[i] / 2000.0;
            v[0] = 16.0;
            // Pick the pair whose product drives the middle-angle sine.
            case (ord)
                0, 1: v[2] = ($urandom_range(1)) ? 16.0 : -16.0;
                default: v[ord == 2 ? 1 : 2] = ($urandom_range(1)) ? 16.0 : -16.0;
            endcase
            if (ord == 0) v[2] = v[2];
            if (ord == 1) begin v[3] = v[2]; v[2] = v[1] / 16.0; end
        end
        n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
        if (n == 0.0) n = 1.0;
        return make_quat($rtoi(v[0] / n * 32767.0), $rtoi(v[1] / n * 32767.0),
                         $rtoi(v[2] / n * 32767.0), $rtoi(v[3] / n * 32767.0), ord);
    endfunction

    // Sender: new item only when the slot is empty or the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                angles_due = {angles_due, euler_of(make_quat(s_quat_w, s_quat_x, s_quat_y,
                                                             s_quat_z, s_rotation_order))};
                n_sent <= n_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (!hold_done && n_sent >= hold_at && (angles_due.size() != 0
                        || (s_valid && s_ready))) begin
                    s_valid <= 1'b0;
                end else if (quat_pending.size() != 0
                        && $urandom_range(99) >= sender_idle_pct) begin
                    quat_item_t q;
                    if (n_sent >= hold_at) hold_done <= 1'b1;
                    q = quat_pending.pop_front();
                    s_quat_w <= q.w;
                    s_quat_x <= q.x;
                    s_quat_y <= q.y;
                    s_quat_z <= q.z;
                    s_rotation_order <= q.order;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker.
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("quaternion_to_euler_angles_tb: FAIL");
            $finish;
        end
        if (n_sent < 600) begin
            sender_idle_pct <= 8;
            receiver_idle_pct <= 78;
        end else if (n_sent < 1200) begin
            sender_idle_pct <= 78;
            receiver_idle_pct <= 8;
        end else begin
            sender_idle_pct <= 0;
            receiver_idle_pct <= 0;
        end
        m_ready <= aresetn && ($urandom_range(99) >= receiver_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (angles_due.size() == 0) begin
                n_errors <= n_errors + 1;
                if (n_errors < 10)
                    $display("unexpected item: x=%0d y=%0d z=%0d lock=%0b",
                             m_angle_x, m_angle_y, m_angle_z, m_gimbal_lock);
            end else begin
                euler_item_t e;
                e = angles_due.pop_front();
                if (e.ax !== m_angle_x || e.ay !== m_angle_y || e.az !== m_angle_z
                        || e.lock !== m_gimbal_lock) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10) begin
                        $display("mismatch: expected x=%0d y=%0d z=%0d lock=%0b",
                                 e.ax, e.ay, e.az, e.lock);
                        $display("          got      x=%0d y=%0d z=%0d lock=%0b",
                                 m_angle_x, m_angle_y, m_angle_z, m_gimbal_lock);
                    end
                end
            end
        end
    end

    initial begin
        int k;
        for (int o = 0; o < 4; o++) begin
            queue_quat(make_quat(0, 0, 0, 0, o));
            queue_quat(make_quat(32767, 0, 0, 0, o));
            queue_quat(make_quat(23171, 23171, 23171, 23171, o));
            queue_quat(make_quat(23171, -23171, 23171, -23171, o));
        end
        queue_quat(make_quat(-32768, -32768, -32768, -32768, qea_pkg::ORD_XYZ));
        queue_quat(make_quat(32767, 32767, 32767, 32767, qea_pkg::ORD_ZYX));
        queue_quat(make_quat(-32768, 0, 0, 0, qea_pkg::ORD_XZY));
        // Middle-angle sine just below and just above the lock threshold.
        queue_quat(make_quat(23170, 0, 23170, 0, qea_pkg::ORD_XYZ));
        queue_quat(make_quat(23171, 0, 23171, 0, qea_pkg::ORD_XYZ));
        queue_quat(make_quat(23171, 0, -23171, 0, qea_pkg::ORD_XYZ));
        queue_quat(make_quat(-23171, 0, 23171, 0, qea_pkg::ORD_YZX));
        // Non-unit input with every component at full scale, and a negative real part.
        queue_quat(make_quat(-32768, 32767, -32768, 32767, qea_pkg::ORD_ZYX));
        queue_quat(make_quat(-20000, 1000, 0, 0, qea_pkg::ORD_XYZ));
        for (int i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(99);
            if (k < 55) queue_quat(unit_quat(1'b0));
            else if (k < 75) queue_quat(unit_quat(1'b1));
            else queue_quat(make_quat(rnd_comp(), rnd_comp(), rnd_comp(),
                                      rnd_comp(), $urandom_range(3)));
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (quat_pending.size() != 0 || s_valid || angles_due.size() != 0)
            @(posedge aclk);
        repeat (NSTEPS + 60) @(posedge aclk);
        if (n_errors == 0 && angles_due.size() == 0)
            $display("quaternion_to_euler_angles_tb: PASS");
        else
            $display("quaternion_to_euler_angles_tb: FAIL");
        $finish;
    end

endmodule
